// ----- hw/rtl/mat4mul_pkg.sv -----
// shared types and constants of the fixed-point matrix multiplier
package mat4mul_pkg;

	localparam logic [1:0] CMD_LOAD_A   = 2'd0;
	localparam logic [1:0] CMD_LOAD_B   = 2'd1;
	localparam logic [1:0] CMD_MULTIPLY = 2'd2;

	localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [1:0]         command;
		logic [1:0]         element_row;
		logic [1:0]         element_col;
		logic signed [31:0] element_value;
	} cmd_req_t;

	typedef struct packed {
		logic [1:0]         out_row;
		logic [1:0]         out_col;
		logic signed [31:0] out_value;
		logic               out_last;
	} res_req_t;

	// travels alongside each read issued to the stores
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} seq_state_t;

endpackage

// ----- hw/rtl/mat4mul_store.sv -----
// the two matrix memories with per-entry valid bits and registered reads
module mat4mul_store #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 we_a,
	input  logic                 we_b,
	input  logic [AW-1:0]        waddr,
	input  logic [31:0]          wdata,
	input  logic [AW-1:0]        raddr_a,
	input  logic [AW-1:0]        raddr_b,
	output logic signed [31:0]   rd_a,
	output logic signed [31:0]   rd_b
);

	logic [31:0]      mem_a [DEPTH];
	logic [31:0]      mem_b [DEPTH];
	logic [DEPTH-1:0] va_q;
	logic [DEPTH-1:0] vb_q;
	logic [31:0]      rda_q;
	logic [31:0]      rdb_q;
	logic             rva_q;
	logic             rvb_q;

	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[waddr] <= wdata;
		end
		if (we_b) begin
			mem_b[waddr] <= wdata;
		end
		rda_q <= mem_a[raddr_a];
		rdb_q <= mem_b[raddr_b];
	end

	// an entry never written since reset reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q  <= '0;
			vb_q  <= '0;
			rva_q <= 1'b0;
			rvb_q <= 1'b0;
		end else begin
			if (we_a) begin
				va_q[waddr] <= 1'b1;
			end
			if (we_b) begin
				vb_q[waddr] <= 1'b1;
			end
			rva_q <= va_q[raddr_a];
			rvb_q <= vb_q[raddr_b];
		end
	end

	assign rd_a = rva_q ? rda_q : '0;
	assign rd_b = rvb_q ? rdb_q : '0;

endmodule

// ----- hw/rtl/mat4mul_mac.sv -----
// multiply-accumulate pipeline with final shift and saturation
module mat4mul_mac #(
	parameter int DIM       = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mat4mul_pkg::mac_ctl_t  ctl,
	input  logic signed [31:0]     a,
	input  logic signed [31:0]     b,
	input  logic                   take,
	output logic                   done,
	output logic [31:0]            value
);

	import mat4mul_pkg::*;

	localparam int ACC_W = 64 + $clog2(DIM);

	mac_ctl_t                 ctl_s1;
	mac_ctl_t                 ctl_s2;
	logic signed [63:0]       prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  shifted;
	logic                     done_q;
	logic                     in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			if (ctl_s2.valid && ctl_s2.last) begin
				done_q <= 1'b1;
			end else if (take) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= 64'(a) * 64'(b);
		if (ctl_s2.valid) begin
			if (ctl_s2.first) begin
				acc_q <= ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	// floor shift, then clamp to the 32-bit signed range
	always_comb begin
		shifted  = acc_q >>> FRAC_BITS;
		in_range = (&shifted[ACC_W-1:31]) || !(|shifted[ACC_W-1:31]);
		if (in_range) begin
			value = shifted[31:0];
		end else if (shifted[ACC_W-1]) begin
			value = SAT_MIN;
		end else begin
			value = SAT_MAX;
		end
	end

	assign done = done_q;

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !ctl_s1.valid && !ctl_s2.valid)
		else $error("result held while products still in flight");

	a_no_issue_held: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.valid |-> !done_q)
		else $error("new dot product issued over an untaken result");

	a_done_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s2.valid && ctl_s2.last) |=> done_q)
		else $error("final term accumulated without raising done");

endmodule

// ----- hw/rtl/matrix4x4_multiply.sv -----
// top level: command decode, dot-product sequencer and result register
//
//  channel  | valid      | stall      | payload | carries
//  ---------+------------+------------+---------+------------------------------
//  command  | cmd_valid  | cmd_stall  | cmd     | load of A or B, or multiply
//  result   | res_valid  | res_stall  | res     | one product element per request
//
// a load is taken while idle; command 3 is taken and dropped.
// during a multiply each element reads one term per cycle from the memories;
// each term passes the registered read, the product register and the
// accumulator before the element lands in the result register.
// reset empties both matrices (all entries read zero) and the result register.
// result stall holds the sequencer before the next element; commands stall
// while a multiply is running.
module matrix4x4_multiply #(
	parameter int DIM       = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  mat4mul_pkg::cmd_req_t  cmd,
	output logic                   res_valid,
	input  logic                   res_stall,
	output mat4mul_pkg::res_req_t  res
);

	import mat4mul_pkg::*;

	localparam int IW    = $clog2(DIM);
	localparam int DEPTH = DIM * DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(DIM - 1);

	seq_state_t         state_q;
	seq_state_t         state_d;
	logic [IW-1:0]      r_q;
	logic [IW-1:0]      c_q;
	logic [IW-1:0]      k_q;
	logic               cmd_take;
	logic               idx_ok;
	logic               we_a;
	logic               we_b;
	logic [AW-1:0]      waddr;
	logic [AW-1:0]      raddr_a;
	logic [AW-1:0]      raddr_b;
	logic signed [31:0] rd_a;
	logic signed [31:0] rd_b;
	mac_ctl_t           mac_ctl;
	logic               mac_done;
	logic [31:0]        mac_value;
	logic               out_load;
	logic               elem_last;
	logic               res_valid_q;
	res_req_t           res_q;

	assign cmd_take  = cmd_valid && !cmd_stall;
	assign idx_ok    = (32'(cmd.element_row) < DIM) && (32'(cmd.element_col) < DIM);
	assign waddr     = AW'(32'(cmd.element_row) * DIM + 32'(cmd.element_col));
	assign we_a      = cmd_take && idx_ok && (cmd.command == CMD_LOAD_A);
	assign we_b      = cmd_take && idx_ok && (cmd.command == CMD_LOAD_B);
	assign raddr_a   = AW'(32'(r_q) * DIM + 32'(k_q));
	assign raddr_b   = AW'(32'(k_q) * DIM + 32'(c_q));
	assign elem_last = (r_q == LAST_IDX) && (c_q == LAST_IDX);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && cmd.command == CMD_MULTIPLY) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (k_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_load) begin
					state_d = elem_last ? ST_IDLE : ST_ISSUE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_stall     = (state_q != ST_IDLE);
		mac_ctl.valid = (state_q == ST_ISSUE);
		mac_ctl.first = (k_q == '0);
		mac_ctl.last  = (k_q == LAST_IDX);
		out_load      = (state_q == ST_DRAIN) && mac_done && (!res_valid_q || !res_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			r_q         <= '0;
			c_q         <= '0;
			k_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_take && cmd.command == CMD_MULTIPLY) begin
				r_q <= '0;
				c_q <= '0;
				k_q <= '0;
			end else if (state_q == ST_ISSUE) begin
				k_q <= (k_q == LAST_IDX) ? '0 : k_q + 1'b1;
			end else if (out_load) begin
				// row-major walk over the product
				if (c_q == LAST_IDX) begin
					c_q <= '0;
					r_q <= r_q + 1'b1;
				end else begin
					c_q <= c_q + 1'b1;
				end
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q.out_row   <= 2'(r_q);
			res_q.out_col   <= 2'(c_q);
			res_q.out_value <= mac_value;
			res_q.out_last  <= elem_last;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	mat4mul_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.we_a    (we_a),
		.we_b    (we_b),
		.waddr   (waddr),
		.wdata   (cmd.element_value),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rd_a    (rd_a),
		.rd_b    (rd_b)
	);

	mat4mul_mac #(
		.DIM       (DIM),
		.FRAC_BITS (FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (rd_a),
		.b      (rd_b),
		.take   (out_load),
		.done   (mac_done),
		.value  (mac_value)
	);

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(we_a || we_b) |-> !mac_done && !mac_ctl.valid)
		else $error("memory written while a multiply is in progress");

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && elem_last) |=> res_q.out_last && res_q.out_col == 2'(DIM - 1))
		else $error("final element not marked at the last column");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_stall) |-> !out_load)
		else $error("result register loaded while held");

endmodule

// ----- tb/sv/tb_matrix4x4_multiply.sv -----
// self-checking testbench for the 4x4 fixed-point matrix multiplier
module tb_matrix4x4_multiply;
	timeunit 1ns;
	timeprecision 1ps;

	import mat4mul_pkg::*;

	localparam int DIM          = 4;
	localparam int FRAC_BITS    = 16;
	localparam int RANDOM_ITEMS = 300;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = DIM * DIM * (DIM + 3) + 20;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// keeps copies of both matrices and the products still owed by the block
	class matrix_product_board;
		logic signed [31:0] left_m [16];
		logic signed [31:0] right_m [16];
		res_req_t pending_products [$];
		int failures;

		function new();
			foreach (left_m[i]) begin
				left_m[i] = '0;
				right_m[i] = '0;
			end
			failures = 0;
		endfunction

		// full-width sum, floor shift, then clamp to 32 bits
		function logic signed [31:0] dot_product(int r, int c);
			logic signed [65:0] acc;
			logic signed [65:0] a;
			logic signed [65:0] b;
			logic signed [49:0] shifted;
			acc = '0;
			for (int k = 0; k < DIM; k++) begin
				a = 66'(left_m[r * DIM + k]);
				b = 66'(right_m[k * DIM + c]);
				acc += a * b;
			end
			shifted = 50'(acc >>> FRAC_BITS);
			if (shifted > 50'sd2147483647)
				return SAT_MAX;
			if (shifted < -50'sd2147483648)
				return SAT_MIN;
			return shifted[31:0];
		endfunction

		function void note_command(cmd_req_t req);
			res_req_t e;
			case (req.command)
				CMD_LOAD_A: left_m[{req.element_row, req.element_col}] = req.element_value;
				CMD_LOAD_B: right_m[{req.element_row, req.element_col}] = req.element_value;
				CMD_MULTIPLY: begin
					for (int r = 0; r < DIM; r++) begin
						for (int c = 0; c < DIM; c++) begin
							e.out_row = 2'(r);
							e.out_col = 2'(c);
							e.out_value = dot_product(r, c);
							e.out_last = (r == DIM - 1 && c == DIM - 1);
							pending_products.push_back(e);
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void check_product(res_req_t got);
			res_req_t e;
			if (pending_products.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected product: row %0d col %0d value %h last %0d",
						got.out_row, got.out_col, got.out_value, got.out_last);
				return;
			end
			e = pending_products.pop_front();
			if (got.out_row !== e.out_row || got.out_col !== e.out_col ||
					got.out_value !== e.out_value || got.out_last !== e.out_last) begin
				failures++;
				if (failures <= 10)
					$display("product mismatch: expected row %0d col %0d value %h last %0d, %s",
						e.out_row, e.out_col, e.out_value, e.out_last,
						$sformatf("got row %0d col %0d value %h last %0d",
							got.out_row, got.out_col, got.out_value, got.out_last));
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     cmd_valid;
	logic     cmd_stall;
	cmd_req_t cmd;
	logic     res_valid;
	logic     res_stall;
	res_req_t res;

	matrix_product_board board;
	bit no_idle;
	int quiet_cycles;
	int sent;
	bit paused;

	matrix4x4_multiply #(
		.DIM(DIM),
		.FRAC_BITS(FRAC_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int draw_wait();
		if (no_idle)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	function automatic cmd_req_t make_cmd(logic [1:0] op, int r, int c, logic [31:0] v);
		cmd_req_t req;
		req.command = op;
		req.element_row = 2'(r);
		req.element_col = 2'(c);
		req.element_value = v;
		return req;
	endfunction

	// small Q16.16 values so sums stay in range in four draws of ten, extremes in one, raw in the rest
	function automatic logic [31:0] draw_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 32'($urandom_range(0, 8 << 16)) - (32'd4 << 16);
			4: begin
				case ($urandom_range(0, 4))
					0: return SAT_MIN;
					1: return SAT_MAX;
					2: return 32'hffff_ffff;
					3: return 32'h0001_0000;
					default: return '0;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	task automatic issue_command(input cmd_req_t req);
		int gap;
		gap = draw_wait();
		@(negedge clk);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= req;
		forever begin
			@(posedge clk);
			if (!cmd_stall)
				break;
		end
		board.note_command(req);
	endtask

	// hold off new requests until every owed product is out
	task automatic wait_products_done();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (board.pending_products.size() != 0)
			@(negedge clk);
	endtask

	task automatic random_load(logic [1:0] op);
		issue_command(make_cmd(op, $urandom_range(0, 3), $urandom_range(0, 3), draw_value()));
	endtask

	// receiver pacing; the check itself sits in the monitor below
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = draw_wait();
			@(negedge clk);
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			res_stall <= 1'b0;
			do
				@(posedge clk);
			while (!res_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			board.check_product(res);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int loads;
		logic [1:0] op;
		board = new();
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		res_stall = 1'b0;
		no_idle = 1'b0;
		quiet_cycles = 0;
		sent = 0;
		paused = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// product of the cleared stores, then a dropped command
		issue_command(make_cmd(CMD_MULTIPLY, 0, 0, $urandom()));
		issue_command(make_cmd(CMD_UNUSED, $urandom_range(0, 3), $urandom_range(0, 3),
			$urandom()));
		// most negative squared four times: positive clamp at row 0
		for (int k = 0; k < DIM; k++)
			issue_command(make_cmd(CMD_LOAD_A, 0, k, SAT_MIN));
		for (int k = 0; k < DIM; k++)
			issue_command(make_cmd(CMD_LOAD_B, k, 0, SAT_MIN));
		// most positive times most negative: negative clamp at row 3 col 3
		for (int k = 0; k < DIM; k++)
			issue_command(make_cmd(CMD_LOAD_A, 3, k, SAT_MAX));
		for (int k = 0; k < DIM; k++)
			issue_command(make_cmd(CMD_LOAD_B, k, 3, SAT_MIN));
		// one negative ulp product must floor to -1
		issue_command(make_cmd(CMD_LOAD_A, 2, 1, 32'hffff_ffff));
		issue_command(make_cmd(CMD_LOAD_B, 1, 2, 32'h0000_0001));
		issue_command(make_cmd(CMD_MULTIPLY, 3, 3, SAT_MAX));
		wait_products_done();

		while (sent < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 5) == 0) begin
				op = $urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A;
				for (int i = 0; i < DIM * DIM; i++)
					issue_command(make_cmd(op, i / DIM, i % DIM, draw_value()));
				sent += DIM * DIM;
			end else begin
				loads = $urandom_range(1, 12);
				for (int i = 0; i < loads; i++) begin
					if ($urandom_range(0, 9) == 0) begin
						issue_command(make_cmd(CMD_UNUSED, $urandom_range(0, 3),
							$urandom_range(0, 3), $urandom()));
					end else begin
						random_load($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A);
						sent++;
					end
				end
			end
			issue_command(make_cmd(CMD_MULTIPLY, $urandom_range(0, 3), $urandom_range(0, 3),
				$urandom()));
			sent++;
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				wait_products_done();
			end
		end

		wait_products_done();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/mat4mul_pkg.sv
hw/rtl/mat4mul_store.sv
hw/rtl/mat4mul_mac.sv
hw/rtl/matrix4x4_multiply.sv
tb/sv/tb_matrix4x4_multiply.sv
